@@ rtl/iax2_frame_header_parser_macros.svh @@
// Assertion macros used by the request queue of the parser RTL.
`ifndef IAX2_FRAME_HEADER_PARSER_MACROS_SVH
`define IAX2_FRAME_HEADER_PARSER_MACROS_SVH

`ifndef SYNTH
`define IAX2_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IAX2_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define IAX2_ASSERT_NOW(lbl, ante, cons)
`define IAX2_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/iax2_pkg.sv @@
// Types, codes and helpers shared by the IAX2 header parser modules.
`timescale 1ns / 1ps
`default_nettype none
package iax2_pkg;

  localparam logic [2:0] KIND_FULL  = 3'd0;
  localparam logic [2:0] KIND_VIDEO = 3'd1;
  localparam logic [2:0] KIND_MINI  = 3'd2;
  localparam logic [2:0] KIND_CHUNK = 3'd3;
  localparam logic [2:0] KIND_TEND  = 3'd4;
  localparam logic [2:0] KIND_DROP  = 3'd5;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [14:0] source_call;
    logic [14:0] dest_call;
    logic        retransmit;
    logic [31:0] timestamp;
    logic [7:0]  out_seq;
    logic [7:0]  in_seq;
    logic [7:0]  frame_type;
    logic [31:0] subclass;
    logic [11:0] payload_offset;
    logic [11:0] payload_length;
    logic        last_result;
  } out_t;

  // One request from the front: an optional chunk and an optional final result.
  typedef struct packed {
    logic chunk_vld;
    out_t chunk;
    logic fin_vld;
    out_t fin;
  } rq_t;

  function automatic logic [31:0] unpack_sub(input logic [7:0] v);
    logic [31:0] r;
    if (v > 8'h9f) begin
      r = {24'd0, v};
    end else if (v[7]) begin
      r = 32'd1 << v[4:0];
    end else begin
      r = {24'd0, v};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/iax2_front.sv @@
// Byte parser: keeps header bytes, splits trunk chunks and classifies datagrams.
`timescale 1ns / 1ps
`default_nettype none
module iax2_front
  import iax2_pkg::*;
#(
  parameter int MAX_DGRAM_BYTES = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_data,
  input  wire logic accept,
  input  wire in_t  in_data,
  output logic      push,
  output rq_t       push_data
);

  localparam int POS_W = $clog2(MAX_DGRAM_BYTES + 2);

  localparam logic [1:0] MODE_HEADER     = 2'd0;
  localparam logic [1:0] MODE_CHUNK_HDR  = 2'd1;
  localparam logic [1:0] MODE_CHUNK_DATA = 2'd2;
  localparam logic [1:0] MODE_REJECT     = 2'd3;

  logic             trunk_en_r;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [7:0]       hdr_r [16];
  logic [7:0]       hdr_nxt [16];
  logic [1:0]       mode_r, mode_nxt;
  logic [47:0]      ch_r, ch_nxt, ch_sh, emit_hdr;
  logic [2:0]       cnt_r, cnt_nxt, cnt_inc, hsize;
  logic [15:0]      left_r, left_nxt, left_dec, emit_dlen, dlen_sh;
  logic             in_range, hs6, chunk_vld;
  logic [15:0]      scn, dcn;
  logic [11:0]      len12;
  logic [7:0]       b;
  out_t             chunk_res, fin_res;

  assign b        = in_data.data_byte;
  assign in_range = pos_r < POS_W'(MAX_DGRAM_BYTES);
  assign pos_inc  = pos_r + POS_W'(1);
  assign pos_nxt  = in_range ? pos_inc : POS_W'(MAX_DGRAM_BYTES + 1);
  assign hs6      = hdr_r[3][0];
  assign hsize    = hs6 ? 3'd6 : 3'd4;
  assign cnt_inc  = cnt_r + 3'd1;
  assign ch_sh    = {ch_r[39:0], b};
  assign dlen_sh  = hs6 ? ch_sh[47:32] : ch_sh[15:0];
  assign left_dec = left_r - 16'd1;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      hdr_nxt[i] = hdr_r[i];
      if (pos_r < POS_W'(16) && pos_r[3:0] == 4'(i)) begin
        hdr_nxt[i] = b;
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    chunk_vld = 1'b0;
    emit_hdr  = ch_r;
    emit_dlen = hs6 ? ch_r[47:32] : ch_r[15:0];
    if (in_range) begin
      case (mode_r)
        MODE_HEADER: begin
          if (pos_r == POS_W'(7) && {hdr_nxt[0], hdr_nxt[1]} == 16'd0 && !hdr_nxt[2][7]) begin
            mode_nxt = (hdr_nxt[2] == 8'd1 && trunk_en_r) ? MODE_CHUNK_HDR : MODE_REJECT;
          end
        end
        MODE_CHUNK_HDR: begin
          ch_nxt  = ch_sh;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= hsize) begin
            cnt_nxt = 3'd0;
            if (dlen_sh == 16'd0) begin
              chunk_vld = 1'b1;
              emit_hdr  = ch_sh;
              emit_dlen = 16'd0;
              ch_nxt    = 48'd0;
            end else begin
              left_nxt = dlen_sh;
              mode_nxt = MODE_CHUNK_DATA;
            end
          end
        end
        MODE_CHUNK_DATA: begin
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            chunk_vld = 1'b1;
            ch_nxt    = 48'd0;
            mode_nxt  = MODE_CHUNK_HDR;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    chunk_res                = '0;
    chunk_res.result_kind    = KIND_CHUNK;
    chunk_res.source_call    = emit_hdr[30:16];
    chunk_res.retransmit     = emit_hdr[31];
    chunk_res.timestamp      = hs6 ? {16'd0, emit_hdr[15:0]} : 32'd0;
    chunk_res.payload_offset = 12'(pos_inc) - emit_dlen[11:0];
    chunk_res.payload_length = emit_dlen[11:0];
  end

  assign scn   = {hdr_nxt[0], hdr_nxt[1]};
  assign dcn   = {hdr_nxt[2], hdr_nxt[3]};
  assign len12 = 12'(pos_nxt);

  always_comb begin
    fin_res             = '0;
    fin_res.last_result = 1'b1;
    fin_res.result_kind = KIND_DROP;
    if (pos_nxt > POS_W'(MAX_DGRAM_BYTES) || pos_nxt < POS_W'(4)) begin
      fin_res.result_kind = KIND_DROP;
    end else if (scn[15]) begin
      if (pos_nxt >= POS_W'(12)) begin
        fin_res.result_kind    = KIND_FULL;
        fin_res.source_call    = scn[14:0];
        fin_res.dest_call      = dcn[14:0];
        fin_res.retransmit     = dcn[15];
        fin_res.timestamp      = {hdr_nxt[4], hdr_nxt[5], hdr_nxt[6], hdr_nxt[7]};
        fin_res.out_seq        = hdr_nxt[8];
        fin_res.in_seq         = hdr_nxt[9];
        fin_res.frame_type     = hdr_nxt[10];
        fin_res.subclass       = unpack_sub(hdr_nxt[11]);
        fin_res.payload_offset = 12'd12;
        fin_res.payload_length = len12 - 12'd12;
      end
    end else if (scn == 16'd0) begin
      if (dcn[15]) begin
        if (pos_nxt >= POS_W'(6)) begin
          fin_res.result_kind    = KIND_VIDEO;
          fin_res.source_call    = dcn[14:0];
          fin_res.retransmit     = hdr_nxt[4][7];
          fin_res.timestamp      = {17'd0, hdr_nxt[4][6:0], hdr_nxt[5]};
          fin_res.payload_offset = 12'd6;
          fin_res.payload_length = len12 - 12'd6;
        end
      end else if (mode_nxt == MODE_CHUNK_HDR) begin
        fin_res.result_kind = KIND_TEND;
      end
    end else begin
      fin_res.result_kind    = KIND_MINI;
      fin_res.source_call    = scn[14:0];
      fin_res.timestamp      = {16'd0, dcn};
      fin_res.payload_offset = 12'd4;
      fin_res.payload_length = len12 - 12'd4;
    end
  end

  assign push                = accept && (chunk_vld || in_data.last_byte);
  assign push_data.chunk_vld = chunk_vld;
  assign push_data.chunk     = chunk_res;
  assign push_data.fin_vld   = in_data.last_byte;
  assign push_data.fin       = fin_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trunk_en_r <= 1'b0;
    end else if (cfg_we) begin
      trunk_en_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mode_r <= MODE_HEADER;
      ch_r   <= '0;
      cnt_r  <= '0;
      left_r <= '0;
      for (int i = 0; i < 16; i++) begin
        hdr_r[i] <= '0;
      end
    end else if (accept) begin
      if (in_data.last_byte) begin
        pos_r  <= '0;
        mode_r <= MODE_HEADER;
        ch_r   <= '0;
        cnt_r  <= '0;
        left_r <= '0;
        for (int i = 0; i < 16; i++) begin
          hdr_r[i] <= '0;
        end
      end else begin
        pos_r  <= pos_nxt;
        mode_r <= mode_nxt;
        ch_r   <= ch_nxt;
        cnt_r  <= cnt_nxt;
        left_r <= left_nxt;
        for (int i = 0; i < 16; i++) begin
          hdr_r[i] <= hdr_nxt[i];
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/iax2_rq.sv @@
// Request queue between the byte parser and the result serializer.
`timescale 1ns / 1ps
`default_nettype none
module iax2_rq
  import iax2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rq_t  push_data,
  output logic      full,
  input  wire logic pop,
  output logic      head_vld,
  output rq_t       head_data
);

  `include "iax2_frame_header_parser_macros.svh"

  rq_t                mem_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [RQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = cnt_r == RQ_CNT_W'(RQ_DEPTH);
  assign head_vld  = cnt_r != '0;
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + RQ_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - RQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + RQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + RQ_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  `IAX2_ASSERT_NOW(a_no_overflow, push, !full || pop)
  `IAX2_ASSERT_NOW(a_no_underflow, pop, head_vld)
  `IAX2_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + RQ_CNT_W'(1))

endmodule
`default_nettype wire

@@ rtl/iax2_back.sv @@
// Result serializer: expands each request into one or two results.
`timescale 1ns / 1ps
`default_nettype none
module iax2_back
  import iax2_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_vld,
  input  wire rq_t  head_data,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic phase_r, phase_nxt;
  logic load;

  assign load = !out_valid_r || !out_stall;

  always_comb begin
    pop           = 1'b0;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt = head_vld;
      if (head_vld) begin
        if (head_data.chunk_vld && !phase_r) begin
          out_data_nxt = head_data.chunk;
          if (head_data.fin_vld) begin
            phase_nxt = 1'b1;
          end else begin
            pop = 1'b1;
          end
        end else begin
          out_data_nxt = head_data.fin;
          pop          = 1'b1;
          phase_nxt    = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

@@ rtl/iax2_frame_header_parser.sv @@
// Top level of the IAX2 datagram header parser.
// Takes one datagram byte per cycle and classifies full, meta video, mini voice and
// meta trunk frames; trunk frames yield one result per voice chunk plus a closing
// result. A byte is taken every cycle while the 4-entry request queue between the
// parser and the output register has room; the first result of a byte passes through the
// request queue and then the output register. A byte that ends both a chunk and the
// datagram gives two results, chunk result first. Results leave at up to one per cycle
// while out_stall is low. The cfg port that writes trunk_enable is always ready.
`timescale 1ns / 1ps
`default_nettype none
module iax2_frame_header_parser
  import iax2_pkg::*;
#(
  parameter int MAX_DGRAM_BYTES = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_data,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic full, push, pop, head_vld, accept;
  rq_t  push_data, head_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  iax2_front #(
    .MAX_DGRAM_BYTES(MAX_DGRAM_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .accept   (accept),
    .in_data  (in_data),
    .push     (push),
    .push_data(push_data)
  );

  iax2_rq u_rq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (full),
    .pop      (pop),
    .head_vld (head_vld),
    .head_data(head_data)
  );

  iax2_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head_data(head_data),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

@@ tb/tb_iax2_frame_header_parser.sv @@
// Self-checking testbench for the IAX2 datagram header parser: table-driven and random datagrams.
`timescale 1ns / 1ps
module tb_iax2_frame_header_parser;
  import iax2_pkg::*;

  localparam int unsigned MAX_DGRAM = 4096;
  localparam int QUIET_LIMIT = 2000;

  typedef enum logic [1:0] {PM_HEADER, PM_CHUNK_HDR, PM_CHUNK_DATA, PM_DISCARD} parse_mode_t;
  typedef enum int {SH_FULL, SH_MINI, SH_VIDEO, SH_TRUNK, SH_NOISE} shape_t;

  typedef struct packed {
    logic [4:0]   n;
    logic         trunk_on;
    logic         fixed;
    logic [2:0]   end_kind;
    logic [127:0] bytes;
  } probe_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic out_stall = 1'b0;
  wire  cfg_ready;
  wire  in_stall;
  wire  out_valid;
  out_t out_data;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  out_t expected_desc[$];
  logic [7:0] dgram_bytes[$];
  probe_t probes[18];

  // Parser state as predicted
  bit             trunk_sink_on = 1'b0;
  int unsigned    pos_cnt = 0;
  logic [7:0]     hdr[16] = '{default: 8'd0};
  parse_mode_t    mode = PM_HEADER;
  logic [47:0]    chunk_sr = '0;
  logic [15:0]    chunk_rem = '0;
  int unsigned    chunk_hcnt = 0;

  iax2_frame_header_parser #(.MAX_DGRAM_BYTES(MAX_DGRAM)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] hword(int unsigned i);
    return {hdr[i], hdr[i + 1]};
  endfunction

  function automatic out_t chunk_desc(int unsigned end_pos, logic [15:0] dlen);
    out_t d;
    d = '0;
    d.result_kind = KIND_CHUNK;
    d.source_call = chunk_sr[30:16];
    d.retransmit = chunk_sr[31];
    d.timestamp = hdr[3][0] ? {16'd0, chunk_sr[15:0]} : 32'd0;
    d.payload_offset = 12'(end_pos - dlen);
    d.payload_length = dlen[11:0];
    return d;
  endfunction

  // Advances the predicted parser by one byte and queues the descriptors it yields.
  function automatic void classify_byte(logic [7:0] b, logic last);
    int unsigned p;
    int unsigned hs;
    logic [15:0] dlen;
    logic [15:0] scn;
    logic [15:0] dcn;
    logic [15:0] t;
    out_t d;
    p = pos_cnt;
    hs = hdr[3][0] ? 6 : 4;
    if (p < MAX_DGRAM) begin
      if (p < 16) hdr[p] = b;
      case (mode)
        PM_HEADER: begin
          if (p == 7 && hword(0) == 16'd0 && !hdr[2][7])
            mode = (hdr[2] == 8'd1 && trunk_sink_on) ? PM_CHUNK_HDR : PM_DISCARD;
        end
        PM_CHUNK_HDR: begin
          chunk_sr = {chunk_sr[39:0], b};
          chunk_hcnt++;
          if (chunk_hcnt >= hs) begin
            dlen = (hs == 6) ? chunk_sr[47:32] : chunk_sr[15:0];
            chunk_hcnt = 0;
            if (dlen == 16'd0) begin
              expected_desc.push_back(chunk_desc(p + 1, 16'd0));
              chunk_sr = '0;
            end else begin
              chunk_rem = dlen;
              mode = PM_CHUNK_DATA;
            end
          end
        end
        PM_CHUNK_DATA: begin
          chunk_rem = chunk_rem - 16'd1;
          if (chunk_rem == 16'd0) begin
            dlen = (hs == 6) ? chunk_sr[47:32] : chunk_sr[15:0];
            expected_desc.push_back(chunk_desc(p + 1, dlen));
            chunk_sr = '0;
            mode = PM_CHUNK_HDR;
          end
        end
        default: ;
      endcase
      pos_cnt = p + 1;
    end else begin
      pos_cnt = MAX_DGRAM + 1;
    end
    if (last) begin
      scn = hword(0);
      dcn = hword(2);
      d = '0;
      d.last_result = 1'b1;
      d.result_kind = KIND_DROP;
      if (pos_cnt > MAX_DGRAM || pos_cnt < 4) begin
        d.result_kind = KIND_DROP;
      end else if (scn[15]) begin
        if (pos_cnt >= 12) begin
          d.result_kind = KIND_FULL;
          d.source_call = scn[14:0];
          d.dest_call = dcn[14:0];
          d.retransmit = dcn[15];
          d.timestamp = {hword(4), hword(6)};
          d.out_seq = hdr[8];
          d.in_seq = hdr[9];
          d.frame_type = hdr[10];
          if (hdr[11] > 8'h9f || !hdr[11][7]) d.subclass = {24'd0, hdr[11]};
          else d.subclass = 32'd1 << (hdr[11] & 8'h7f);
          d.payload_offset = 12'd12;
          d.payload_length = 12'(pos_cnt - 12);
        end
      end else if (scn == 16'd0) begin
        if (dcn[15]) begin
          if (pos_cnt >= 6) begin
            t = hword(4);
            d.result_kind = KIND_VIDEO;
            d.source_call = dcn[14:0];
            d.retransmit = t[15];
            d.timestamp = {17'd0, t[14:0]};
            d.payload_offset = 12'd6;
            d.payload_length = 12'(pos_cnt - 6);
          end
        end else if (mode == PM_CHUNK_HDR) begin
          d.result_kind = KIND_TEND;
        end
      end else begin
        d.result_kind = KIND_MINI;
        d.source_call = scn[14:0];
        d.timestamp = {16'd0, dcn};
        d.payload_offset = 12'd4;
        d.payload_length = 12'(pos_cnt - 4);
      end
      expected_desc.push_back(d);
      pos_cnt = 0;
      hdr = '{default: 8'd0};
      mode = PM_HEADER;
      chunk_sr = '0;
      chunk_rem = '0;
      chunk_hcnt = 0;
    end
  endfunction

  function automatic void add_chunk_hdr(bit timed, logic [15:0] dlen);
    logic [15:0] call;
    logic [15:0] stamp;
    call = 16'($urandom);
    stamp = 16'($urandom);
    if (timed) begin
      dgram_bytes.push_back(dlen[15:8]);
      dgram_bytes.push_back(dlen[7:0]);
      dgram_bytes.push_back(call[15:8]);
      dgram_bytes.push_back(call[7:0]);
      dgram_bytes.push_back(stamp[15:8]);
      dgram_bytes.push_back(stamp[7:0]);
    end else begin
      dgram_bytes.push_back(call[15:8]);
      dgram_bytes.push_back(call[7:0]);
      dgram_bytes.push_back(dlen[15:8]);
      dgram_bytes.push_back(dlen[7:0]);
    end
  endfunction

  function automatic void compose_dgram(shape_t shape, bit allow_flaws);
    int unsigned n;
    int unsigned cut;
    logic [15:0] dlen;
    bit timed;
    dgram_bytes.delete();
    n = 0;
    case (shape)
      SH_FULL: begin
        dgram_bytes.push_back({1'b1, 7'($urandom)});
        repeat (10) dgram_bytes.push_back(8'($urandom));
        dgram_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'h9f))
                                                : 8'($urandom));
        n = $urandom_range(0, 30);
      end
      SH_MINI: begin
        dgram_bytes.push_back(8'($urandom_range(0, 127)));
        dgram_bytes.push_back(8'($urandom));
        if (dgram_bytes[0] == 8'd0 && dgram_bytes[1] == 8'd0) dgram_bytes[1] = 8'd1;
        repeat (2) dgram_bytes.push_back(8'($urandom));
        n = $urandom_range(0, 30);
      end
      SH_VIDEO: begin
        repeat (2) dgram_bytes.push_back(8'd0);
        dgram_bytes.push_back({1'b1, 7'($urandom)});
        repeat (3) dgram_bytes.push_back(8'($urandom));
        n = $urandom_range(0, 20);
      end
      SH_TRUNK: begin
        timed = 1'($urandom_range(1));
        repeat (2) dgram_bytes.push_back(8'd0);
        dgram_bytes.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(0, 127)) : 8'd1);
        dgram_bytes.push_back({7'($urandom), timed});
        repeat (4) dgram_bytes.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
          dlen = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 60))
                                          : 16'($urandom_range(0, 8));
          add_chunk_hdr(timed, dlen);
          repeat (dlen) dgram_bytes.push_back(8'($urandom));
        end
        if (allow_flaws) begin
          case ($urandom_range(9))
            7: repeat ($urandom_range(1, timed ? 5 : 3)) dgram_bytes.push_back(8'($urandom));
            8, 9: begin
              dlen = $urandom_range(1) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(1, 12));
              add_chunk_hdr(timed, dlen);
              repeat ($urandom_range(0, (dlen > 10) ? 10 : dlen - 1))
                dgram_bytes.push_back(8'($urandom));
            end
            default: ;
          endcase
        end
      end
      default: n = $urandom_range(1, 20);
    endcase
    repeat (n) dgram_bytes.push_back(8'($urandom));
    if (allow_flaws && $urandom_range(99) < 8) begin
      cut = $urandom_range(1, 11);
      while (dgram_bytes.size() > cut) void'(dgram_bytes.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input bit burst);
    if (!burst && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: l};
    do @(posedge clk); while (in_stall);
    classify_byte(b, l);
  endtask

  task automatic send_dgram(input bit burst);
    for (int i = 0; i < dgram_bytes.size(); i++)
      send_byte(dgram_bytes[i], i == dgram_bytes.size() - 1, burst);
  endtask

  // Drain all outstanding descriptors, then give the pipeline time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_desc.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_trunk(input bit v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    trunk_sink_on = v;
  endtask

  always @(posedge clk) begin
    out_t want;
    string bad;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_desc.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected descriptor %p", out_data);
      end else begin
        want = expected_desc.pop_front();
        bad = "";
        if (out_data.result_kind !== want.result_kind) bad = {bad, " result_kind"};
        if (out_data.source_call !== want.source_call) bad = {bad, " source_call"};
        if (out_data.dest_call !== want.dest_call) bad = {bad, " dest_call"};
        if (out_data.retransmit !== want.retransmit) bad = {bad, " retransmit"};
        if (out_data.timestamp !== want.timestamp) bad = {bad, " timestamp"};
        if (out_data.out_seq !== want.out_seq) bad = {bad, " out_seq"};
        if (out_data.in_seq !== want.in_seq) bad = {bad, " in_seq"};
        if (out_data.frame_type !== want.frame_type) bad = {bad, " frame_type"};
        if (out_data.subclass !== want.subclass) bad = {bad, " subclass"};
        if (out_data.payload_offset !== want.payload_offset) bad = {bad, " payload_offset"};
        if (out_data.payload_length !== want.payload_length) bad = {bad, " payload_length"};
        if (out_data.last_result !== want.last_result) bad = {bad, " last_result"};
        if (bad != "") begin
          mismatches++;
          if (mismatches <= 10)
            $display("descriptor mismatch in%s: expected %p, got %p", bad, want, out_data);
        end
      end
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    int ph;
    int r;
    int unsigned sent;
    out_t fixed_d;
    shape_t sh;
    probes = '{
      '{5'd12, 1'b0, 1'b1, KIND_DROP, 128'h00000100_00000000_ffff0000_00000000},
      '{5'd3,  1'b1, 1'b1, KIND_DROP, 128'hffffff00_00000000_00000000_00000000},
      '{5'd11, 1'b1, 1'b1, KIND_DROP, 128'h80010002_00000000_00000000_00000000},
      '{5'd12, 1'b1, 1'b0, KIND_FULL, 128'hffffffff_ffffffff_ffffffff_00000000},
      '{5'd12, 1'b1, 1'b0, KIND_FULL, 128'h80000000_00000000_0000009f_00000000},
      '{5'd13, 1'b1, 1'b0, KIND_FULL, 128'h80007fff_00000001_01020380_5a000000},
      '{5'd4,  1'b1, 1'b0, KIND_FULL, 128'h0001ffff_00000000_00000000_00000000},
      '{5'd5,  1'b1, 1'b0, KIND_FULL, 128'h7fff0000_a5000000_00000000_00000000},
      '{5'd5,  1'b1, 1'b1, KIND_DROP, 128'h00008000_00000000_00000000_00000000},
      '{5'd6,  1'b1, 1'b0, KIND_FULL, 128'h0000ffff_ffff0000_00000000_00000000},
      '{5'd8,  1'b1, 1'b1, KIND_DROP, 128'h00000200_00000000_00000000_00000000},
      '{5'd7,  1'b1, 1'b1, KIND_DROP, 128'h00000100_00000000_00000000_00000000},
      '{5'd8,  1'b1, 1'b1, KIND_TEND, 128'h00000100_12345678_00000000_00000000},
      '{5'd12, 1'b1, 1'b0, KIND_FULL, 128'h00000100_00000001_ffff0000_00000000},
      '{5'd15, 1'b1, 1'b0, KIND_FULL, 128'h00000101_ffffffff_00018005_ffffaa00},
      '{5'd13, 1'b1, 1'b1, KIND_DROP, 128'h00000100_00000000_00070002_11000000},
      '{5'd12, 1'b1, 1'b1, KIND_DROP, 128'h00000100_00000000_00070001_00000000},
      '{5'd10, 1'b1, 1'b1, KIND_TEND, 128'h00000100_00000000_12340000_00000000}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Table part; the first row runs with trunking at its reset value.
    for (k = 0; k < 18; k++) begin
      if (probes[k].trunk_on != trunk_sink_on) set_trunk(probes[k].trunk_on);
      dgram_bytes.delete();
      for (int i = 0; i < probes[k].n; i++)
        dgram_bytes.push_back(probes[k].bytes[127 - 8 * i -: 8]);
      send_dgram(1'b1);
      if (probes[k].fixed) begin
        fixed_d = '0;
        fixed_d.result_kind = probes[k].end_kind;
        fixed_d.last_result = 1'b1;
        expected_desc[expected_desc.size() - 1] = fixed_d;
      end
    end

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 47; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 47; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      set_trunk(ph != 1);
      sent = 0;
      while (sent < 250) begin
        r = $urandom_range(99);
        sh = (r < 20) ? SH_FULL : (r < 35) ? SH_MINI : (r < 45) ? SH_VIDEO :
             (r < 88) ? SH_TRUNK : SH_NOISE;
        compose_dgram(sh, 1'b1);
        sent += dgram_bytes.size();
        send_dgram($urandom_range(3) == 0);
      end
    end

    // Oversized trunk: chunks stop at the limit and the end is dropped.
    compose_dgram(SH_TRUNK, 1'b0);
    dgram_bytes[2] = 8'd1;
    while (dgram_bytes.size() < MAX_DGRAM + 3) dgram_bytes.push_back(8'd0);
    send_dgram(1'b0);

    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_desc.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
